@@ src/tbp_pkg.sv @@
// Shared types and constants for the temperature-to-burst switch controller.
// Used by tbp_divider and temp_to_burst_pwm; depends on nothing else.
`timescale 1ns / 1ps

package tbp_pkg;

    // Widths of the temperature, on-count and tick-count values.
    localparam int TEMP_W = 7;

    // Serial divider operand widths and step counter width.
    localparam int DIV_W     = 16;
    localparam int DEN_W     = 7;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    // Reading to whole degrees: multiply by 2^19 / 10 rounded up, then shift
    // right by 19. This is exact for every reading of up to 16 bits.
    localparam logic [DIV_W-1:0] DEG_RECIP = 16'd52429;
    localparam int               DEG_SHIFT = 19;

    // Largest temperature that fits in the stored field.
    localparam logic [TEMP_W-1:0] TEMP_MAX = 7'd127;

    // Reset values of the bound registers.
    localparam logic [TEMP_W-1:0] TEMP_LOW_RST  = 7'd30;
    localparam logic [TEMP_W-1:0] TEMP_HIGH_RST = 7'd60;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_HIGH = 1'b1;

    // Input command codes.
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // Divider request from the sequencer.
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    // Divider status back to the sequencer.
    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
    } div_rsp_t;

endpackage

@@ src/tbp_divider.sv @@
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on tbp_pkg for operand widths and the request/response structs.
`timescale 1ns / 1ps

module tbp_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  tbp_pkg::div_req_t  req,
    output tbp_pkg::div_rsp_t  rsp
);

    logic [tbp_pkg::DEN_W-1:0]     rem_reg,  rem_next;
    logic [tbp_pkg::DEN_W-1:0]     den_reg,  den_next;
    logic [tbp_pkg::DIV_W-1:0]     quot_reg, quot_next;
    logic [tbp_pkg::DIV_CNT_W-1:0] cnt_reg,  cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [tbp_pkg::DEN_W:0]       shifted;
    logic [tbp_pkg::DEN_W:0]       diff;
    logic                          fits;

    // One trial subtraction of the shifted partial remainder.
    always_comb
    begin
        shifted = {rem_reg, quot_reg[tbp_pkg::DIV_W-1]};
        diff    = shifted - {1'b0, den_reg};
        fits    = (shifted >= {1'b0, den_reg});
    end

    // Step sequencing: load on start, then shift one bit per cycle.
    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            den_next  = req.den;
            quot_next = req.num;
            cnt_next  = tbp_pkg::DIV_CNT_W'(tbp_pkg::DIV_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[tbp_pkg::DEN_W-1:0] : shifted[tbp_pkg::DEN_W-1:0];
            quot_next = {quot_reg[tbp_pkg::DIV_W-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == tbp_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state is reset; the datapath needs none.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

@@ src/temp_to_burst_pwm.sv @@
// Top level of the temperature-driven burst-fire switch controller.
// Depends on tbp_pkg and tbp_divider.
`timescale 1ns / 1ps

// Usage:
// Input beats (in_valid/in_ready) carry command and adc_sample. A sample
// beat converts the reading to degrees, restarts the switching window and
// sets the on-count from a linear curve between temp_low and temp_high. A
// tick beat decides the relay level for this tick and advances the window.
// Every input beat yields exactly one output beat (out_valid/out_ready)
// with drive_on, on_ticks and temperature.
// Bounds go through cfg_valid/cfg_ready/cfg_index/cfg_data, index 0 for temp_low and
// 1 for temp_high. The user must write them only while idle; the block does not check.
// A tick beat goes from idle to the finish state, which loads its output beat. A
// sample beat passes the decide state, which sets the on-count itself outside the
// bounds and else starts the serial divider and waits in the divide state. The
// conversion to degrees is a reciprocal multiplication in the accepting cycle.
// One beat is worked on at a time; in_ready is high only while idle, and the
// next beat can be accepted the cycle after a result is loaded.
// A finished result waits in the output register while the next beat is
// accepted; if the receiver stalls, the block holds the next result until
// the output register frees up.
// Reset clears the window, on-count, level and temperature and loads the
// bounds with 30 and 60 degrees.

module temp_to_burst_pwm #(
    parameter int WINDOW_TICKS = 100,
    parameter int ADC_BITS     = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          command,
    input  logic [ADC_BITS-1:0]           adc_sample,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          drive_on,
    output logic [tbp_pkg::TEMP_W-1:0]    on_ticks,
    output logic [tbp_pkg::TEMP_W-1:0]    temperature,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tbp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tbp_pkg::TEMP_W-1:0]    cfg_data
);

    localparam int TW = tbp_pkg::TEMP_W;
    localparam int QW = 2 * tbp_pkg::DIV_W - tbp_pkg::DEG_SHIFT;
    localparam logic [TW-1:0] WIN = TW'(WINDOW_TICKS);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_DIV_ON = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0]    state_reg,       state_next;
    logic [TW-1:0] temp_low_reg,    temp_low_next;
    logic [TW-1:0] temp_high_reg,   temp_high_next;
    logic [TW-1:0] tick_count_reg,  tick_count_next;
    logic [TW-1:0] on_count_reg,    on_count_next;
    logic          drive_flag_reg,  drive_flag_next;
    logic [TW-1:0] last_temp_reg,   last_temp_next;
    logic          out_valid_reg,   out_valid_next;
    logic          drive_on_reg,    drive_on_next;
    logic [TW-1:0] on_ticks_reg,    on_ticks_next;
    logic [TW-1:0] temperature_reg, temperature_next;

    tbp_pkg::div_req_t div_req;
    tbp_pkg::div_rsp_t div_rsp;

    logic                         in_beat;
    logic                         cfg_beat;
    logic [tbp_pkg::DIV_W-1:0]    adc_wide;
    logic [2*tbp_pkg::DIV_W-1:0]  deg_prod;
    logic [QW-1:0]                deg_quot;
    logic [TW-1:0]                temp_sat;
    logic [TW-1:0]                span_diff;
    logic [2*TW-1:0]              interp_num;
    logic [TW-1:0]                window_start;
    logic                         tick_level;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_beat   = in_valid && in_ready;
    assign cfg_beat  = cfg_valid && cfg_ready;

    // Serial divider for the interpolation.
    tbp_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Degrees from the reading by reciprocal multiplication, saturated to the field width.
    assign adc_wide = tbp_pkg::DIV_W'(adc_sample);
    assign deg_prod = {{tbp_pkg::DIV_W{1'b0}}, adc_wide}
                    * {{tbp_pkg::DIV_W{1'b0}}, tbp_pkg::DEG_RECIP};
    assign deg_quot = deg_prod[2*tbp_pkg::DIV_W-1:tbp_pkg::DEG_SHIFT];
    assign temp_sat = (|deg_quot[QW-1:TW]) ? tbp_pkg::TEMP_MAX : deg_quot[TW-1:0];

    // Interpolation numerator: window length times distance above the low bound.
    assign span_diff  = last_temp_reg - temp_low_reg;
    assign interp_num = {{TW{1'b0}}, WIN} * {{TW{1'b0}}, span_diff};

    // Level for a tick: on during the last on-count ticks of the window.
    assign window_start = (on_count_reg >= WIN) ? '0 : (WIN - on_count_reg);
    assign tick_level   = (on_count_reg != '0) && (tick_count_reg >= window_start);

    // Sequencer and state update.
    always_comb
    begin
        state_next       = state_reg;
        temp_low_next    = temp_low_reg;
        temp_high_next   = temp_high_reg;
        tick_count_next  = tick_count_reg;
        on_count_next    = on_count_reg;
        drive_flag_next  = drive_flag_reg;
        last_temp_next   = last_temp_reg;
        out_valid_next   = out_valid_reg;
        drive_on_next    = drive_on_reg;
        on_ticks_next    = on_ticks_reg;
        temperature_next = temperature_reg;
        div_req.start    = 1'b0;
        div_req.num      = tbp_pkg::DIV_W'(interp_num);
        div_req.den      = temp_high_reg - temp_low_reg;

        // Bound register writes.
        if (cfg_beat)
        begin
            case (cfg_index)
                tbp_pkg::CFG_TEMP_LOW:  temp_low_next  = cfg_data;
                tbp_pkg::CFG_TEMP_HIGH: temp_high_next = cfg_data;
                default: ;
            endcase
        end

        // The output register empties when the receiver takes its beat.
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    if (command == tbp_pkg::CMD_TICK)
                    begin
                        drive_flag_next = tick_level;
                        if (tick_count_reg < WIN)
                        begin
                            tick_count_next = tick_count_reg + 1'b1;
                        end
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        last_temp_next  = temp_sat;
                        tick_count_next = '0;
                        state_next      = ST_DECIDE;
                    end
                end
            end
            ST_DECIDE:
            begin
                if (last_temp_reg < temp_low_reg)
                begin
                    on_count_next = '0;
                    state_next    = ST_FINISH;
                end
                else if (last_temp_reg >= temp_high_reg)
                begin
                    on_count_next = WIN;
                    state_next    = ST_FINISH;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = ST_DIV_ON;
                end
            end
            ST_DIV_ON:
            begin
                if (div_rsp.done)
                begin
                    on_count_next = div_rsp.quot[TW-1:0];
                    state_next    = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // Load the result once the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    drive_on_next    = drive_flag_reg;
                    on_ticks_next    = on_count_reg;
                    temperature_next = last_temp_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and architectural state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            temp_low_reg   <= tbp_pkg::TEMP_LOW_RST;
            temp_high_reg  <= tbp_pkg::TEMP_HIGH_RST;
            tick_count_reg <= '0;
            on_count_reg   <= '0;
            drive_flag_reg <= 1'b0;
            last_temp_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            temp_low_reg   <= temp_low_next;
            temp_high_reg  <= temp_high_next;
            tick_count_reg <= tick_count_next;
            on_count_reg   <= on_count_next;
            drive_flag_reg <= drive_flag_next;
            last_temp_reg  <= last_temp_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        drive_on_reg    <= drive_on_next;
        on_ticks_reg    <= on_ticks_next;
        temperature_reg <= temperature_next;
    end

    assign out_valid   = out_valid_reg;
    assign drive_on    = drive_on_reg;
    assign on_ticks    = on_ticks_reg;
    assign temperature = temperature_reg;

    // The on-count never exceeds the window.
    assert property (@(posedge clk) disable iff (!rst_n)
        on_count_reg <= WIN)
        else $error("on-count exceeds the window length");

    // The tick counter saturates at the window length.
    assert property (@(posedge clk) disable iff (!rst_n)
        tick_count_reg <= WIN)
        else $error("tick counter ran past the window length");

    // The relay level changes only in answer to a tick beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        (drive_flag_reg != $past(drive_flag_reg)) |->
            $past(in_beat && (command == tbp_pkg::CMD_TICK)))
        else $error("relay level changed without a tick beat");

    // The divider finishes only while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_DIV_ON))
        else $error("divider finished outside the divide state");

    // A finishing beat with a free output register fills it.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FINISH) && !out_valid_reg) |=> out_valid_reg)
        else $error("result was not loaded into a free output register");

endmodule
